// ===== sv/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge outside reset
`define GDA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication, sampled on the rising clock edge outside reset
`define GDA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// ===== sv/gda_pkg.sv =====
// types, constants and tables for the gregorian date arithmetic block
package gda_pkg;

    // result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_DATE = 2'd1;
    localparam logic [1:0] STATUS_YEAR_OVF = 2'd2;

    // year / 100 by reciprocal multiply, exact for years below 4097
    localparam int          RECIP_SHIFT = 19;
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam logic [6:0]  CENTURY     = 7'd100;
    localparam logic [8:0]  YEAR_DAYS   = 9'd365;

    // micro-operations of the datapath
    typedef enum logic [3:0] {
        UOP_NOP,
        UOP_LOAD_A,
        UOP_LOAD_B,
        UOP_LEAP_Q,
        UOP_LEAP_F,
        UOP_DN_MUL,
        UOP_DN_ADD,
        UOP_ADD_INIT,
        UOP_MONTH,
        UOP_YEAR,
        UOP_OUT_DIFF,
        UOP_OUT_SUM,
        UOP_OUT_INV,
        UOP_OUT_OVF
    } uop_t;

    // jump conditions, jump taken when true, otherwise fall through
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_INVALID,
        COND_ADD,
        COND_FITS,
        COND_SKIP_YEAR,
        COND_NO_WRAP,
        COND_YEAR_OVF
    } cond_t;

    localparam int UCODE_DEPTH = 32;
    localparam int PC_W        = $clog2(UCODE_DEPTH);

    typedef logic [PC_W-1:0] upc_t;

    typedef struct packed {
        uop_t  op;
        cond_t cond;
        upc_t  target;
    } ucode_t;

    // jump targets
    localparam upc_t S_ADD_INIT = upc_t'(14);
    localparam upc_t S_FITS     = upc_t'(15);
    localparam upc_t S_NEW_YEAR = upc_t'(18);
    localparam upc_t S_YEAR     = upc_t'(21);
    localparam upc_t S_OUT_SUM  = upc_t'(22);
    localparam upc_t S_OUT_INV  = upc_t'(23);
    localparam upc_t S_OUT_OVF  = upc_t'(24);
    localparam upc_t S_NONE     = upc_t'(0);

    // control program
    localparam ucode_t UCODE_ROM [UCODE_DEPTH] = '{
        // date a: load, leap flag, check, branch on operation
        '{UOP_LOAD_A,   COND_NEVER,     S_NONE},
        '{UOP_LEAP_Q,   COND_NEVER,     S_NONE},
        '{UOP_LEAP_F,   COND_NEVER,     S_NONE},
        '{UOP_NOP,      COND_INVALID,   S_OUT_INV},
        '{UOP_NOP,      COND_ADD,       S_ADD_INIT},
        // day number of a, then of b, then the difference
        '{UOP_DN_MUL,   COND_NEVER,     S_NONE},
        '{UOP_DN_ADD,   COND_NEVER,     S_NONE},
        '{UOP_LOAD_B,   COND_NEVER,     S_NONE},
        '{UOP_LEAP_Q,   COND_NEVER,     S_NONE},
        '{UOP_LEAP_F,   COND_NEVER,     S_NONE},
        '{UOP_NOP,      COND_INVALID,   S_OUT_INV},
        '{UOP_DN_MUL,   COND_NEVER,     S_NONE},
        '{UOP_DN_ADD,   COND_NEVER,     S_NONE},
        '{UOP_OUT_DIFF, COND_NEVER,     S_NONE},
        // add days: month walk with whole-year skips from january
        '{UOP_ADD_INIT, COND_NEVER,     S_NONE},
        '{UOP_NOP,      COND_FITS,      S_OUT_SUM},
        '{UOP_NOP,      COND_SKIP_YEAR, S_YEAR},
        '{UOP_MONTH,    COND_NO_WRAP,   S_FITS},
        '{UOP_NOP,      COND_YEAR_OVF,  S_OUT_OVF},
        '{UOP_LEAP_Q,   COND_NEVER,     S_NONE},
        '{UOP_LEAP_F,   COND_ALWAYS,    S_FITS},
        '{UOP_YEAR,     COND_ALWAYS,    S_NEW_YEAR},
        // result steps
        '{UOP_OUT_SUM,  COND_NEVER,     S_NONE},
        '{UOP_OUT_INV,  COND_NEVER,     S_NONE},
        '{UOP_OUT_OVF,  COND_NEVER,     S_NONE},
        // unused entries end the item as a bad date
        '{UOP_OUT_INV,  COND_NEVER,     S_NONE},
        '{UOP_OUT_INV,  COND_NEVER,     S_NONE},
        '{UOP_OUT_INV,  COND_NEVER,     S_NONE},
        '{UOP_OUT_INV,  COND_NEVER,     S_NONE},
        '{UOP_OUT_INV,  COND_NEVER,     S_NONE},
        '{UOP_OUT_INV,  COND_NEVER,     S_NONE},
        '{UOP_OUT_INV,  COND_NEVER,     S_NONE}
    };

    // length of a month, zero for a month code that means nothing
    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7,
            4'd8, 4'd10, 4'd12:        len = 5'd31;
            default:                   len = 5'd0;
        endcase
        return len;
    endfunction

    // days in the months before month m of a common year
    function automatic logic [8:0] days_before(input logic [3:0] m);
        logic [8:0] n;
        case (m)
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

endpackage

// ===== sv/gregorian_date_arithmetic.sv =====
// top level of the gregorian date arithmetic block, microcoded sequencer
//
// Input channel: in_valid / in_stall with the fields action, day_a, month_a,
// year_a, day_b, month_b, year_b and days_to_add. An item is taken when
// in_valid is high and in_stall is low. One item is worked at a time;
// in_stall is high from the cycle after acceptance until the item's result
// has been written to the output register.
// Output channel: out_valid / out_stall with status, day_difference,
// result_day, result_month and result_year, one result per item.
// The sequencer steps through the control program one control word a cycle,
// except while a finished item holds in its last step; add mode walks months
// and skips whole years from january.
// The output register lets a new item be accepted while a result waits; a
// finished item holds in its last step while an earlier result is stalled.
// Reset clears the sequencer and the output valid flag; nothing is kept
// between items.
module gregorian_date_arithmetic #(
    parameter int YEAR_MAX = 4095
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               action,
    input  logic [4:0]         day_a,
    input  logic [3:0]         month_a,
    input  logic [11:0]        year_a,
    input  logic [4:0]         day_b,
    input  logic [3:0]         month_b,
    input  logic [11:0]        year_b,
    input  logic [15:0]        days_to_add,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic signed [21:0] day_difference,
    output logic [4:0]         result_day,
    output logic [3:0]         result_month,
    output logic [11:0]        result_year
);

    localparam int          YEAR_LIM = (YEAR_MAX < 4095) ? YEAR_MAX : 4095;
    localparam logic [12:0] LIM_Y    = 13'(YEAR_LIM);
    localparam logic [11:0] LIM_OUT  = 12'(YEAR_LIM);

    // control state
    logic              busy_reg, busy_next;
    gda_pkg::upc_t     pc_reg, pc_next;
    logic              out_valid_reg, out_valid_next;

    // captured item
    logic              act_reg, act_next;
    logic [4:0]        da_reg, da_next, db_reg, db_next;
    logic [3:0]        ma_reg, ma_next, mb_reg, mb_next;
    logic [11:0]       ya_reg, ya_next, yb_reg, yb_next;
    logic [15:0]       add_reg, add_next;

    // working registers
    logic [12:0]       y_reg, y_next;
    logic [3:0]        m_reg, m_next;
    logic [16:0]       d_reg, d_next;
    logic [5:0]        q_reg, q_next;
    logic [5:0]        qp_reg, qp_next;
    logic              leap_reg, leap_next;
    logic [20:0]       acc_reg, acc_next;
    logic [20:0]       na_reg, na_next;

    // output register
    logic [1:0]        status_reg, status_next;
    logic [21:0]       diff_reg, diff_next;
    logic [4:0]        rday_reg, rday_next;
    logic [3:0]        rmon_reg, rmon_next;
    logic [11:0]       ryear_reg, ryear_next;

    // datapath terms
    gda_pkg::ucode_t   uw;
    logic [4:0]        mdays;
    logic [8:0]        year_len;
    logic [25:0]       q_prod;
    logic [12:0]       rem100;
    logic [12:0]       p_year;
    logic [21:0]       mul365;
    logic [20:0]       dn_sum;
    logic [21:0]       diff_val;
    logic              date_bad;
    logic              cond_hit;
    logic              out_hold;

    assign uw       = gda_pkg::UCODE_ROM[pc_reg];
    assign mdays    = gda_pkg::month_days(m_reg, leap_reg);
    assign year_len = leap_reg ? (gda_pkg::YEAR_DAYS + 9'd1) : gda_pkg::YEAR_DAYS;
    assign out_hold = out_valid_reg && out_stall;

    // century quotient and remainder for the leap rule
    assign q_prod = 26'(y_reg * gda_pkg::RECIP_100);
    assign rem100 = y_reg - 13'(q_reg * gda_pkg::CENTURY);

    // day number pieces: (y-1)*365, then the leap corrections and the day
    assign p_year = y_reg - 13'd1;
    assign mul365 = 22'(p_year * gda_pkg::YEAR_DAYS);
    assign dn_sum = acc_reg + 21'(p_year[12:2]) - 21'(qp_reg) + 21'(qp_reg[5:2])
                  + 21'(gda_pkg::days_before(m_reg))
                  + 21'((m_reg > 4'd2) && leap_reg) + 21'(d_reg);
    assign diff_val = {1'b0, na_reg} - {1'b0, acc_reg};

    // date check on the working registers
    assign date_bad = (y_reg == 13'd0) || (y_reg > LIM_Y) || (d_reg == 17'd0)
                   || (d_reg > 17'(mdays));

    // jump condition
    always_comb
    begin
        case (uw.cond)
            gda_pkg::COND_NEVER:     cond_hit = 1'b0;
            gda_pkg::COND_ALWAYS:    cond_hit = 1'b1;
            gda_pkg::COND_INVALID:   cond_hit = date_bad;
            gda_pkg::COND_ADD:       cond_hit = act_reg;
            gda_pkg::COND_FITS:      cond_hit = d_reg <= 17'(mdays);
            gda_pkg::COND_SKIP_YEAR: cond_hit = (m_reg == 4'd1) && (d_reg > 17'(year_len));
            gda_pkg::COND_NO_WRAP:   cond_hit = m_reg != 4'd12;
            gda_pkg::COND_YEAR_OVF:  cond_hit = y_reg > LIM_Y;
            default:                 cond_hit = 1'b0;
        endcase
    end

    // sequencer and datapath next state
    always_comb
    begin
        busy_next      = busy_reg;
        pc_next        = pc_reg;
        out_valid_next = out_valid_reg && out_stall;
        act_next       = act_reg;
        da_next        = da_reg;
        ma_next        = ma_reg;
        ya_next        = ya_reg;
        db_next        = db_reg;
        mb_next        = mb_reg;
        yb_next        = yb_reg;
        add_next       = add_reg;
        y_next         = y_reg;
        m_next         = m_reg;
        d_next         = d_reg;
        q_next         = q_reg;
        qp_next        = qp_reg;
        leap_next      = leap_reg;
        acc_next       = acc_reg;
        na_next        = na_reg;
        status_next    = status_reg;
        diff_next      = diff_reg;
        rday_next      = rday_reg;
        rmon_next      = rmon_reg;
        ryear_next     = ryear_reg;

        if (!busy_reg)
        begin
            // take a new item
            if (in_valid)
            begin
                busy_next = 1'b1;
                pc_next   = '0;
                act_next  = action;
                da_next   = day_a;
                ma_next   = month_a;
                ya_next   = year_a;
                db_next   = day_b;
                mb_next   = month_b;
                yb_next   = year_b;
                add_next  = days_to_add;
            end
        end
        else
        begin
            pc_next = cond_hit ? uw.target : pc_reg + gda_pkg::upc_t'(1);
            case (uw.op)
                gda_pkg::UOP_NOP:
                begin
                end
                gda_pkg::UOP_LOAD_A:
                begin
                    y_next = {1'b0, ya_reg};
                    m_next = ma_reg;
                    d_next = 17'(da_reg);
                end
                gda_pkg::UOP_LOAD_B:
                begin
                    y_next  = {1'b0, yb_reg};
                    m_next  = mb_reg;
                    d_next  = 17'(db_reg);
                    na_next = acc_reg;
                end
                gda_pkg::UOP_LEAP_Q:
                begin
                    q_next = q_prod[gda_pkg::RECIP_SHIFT +: 6];
                end
                gda_pkg::UOP_LEAP_F:
                begin
                    leap_next = ((y_reg[1:0] == 2'd0) && (rem100 != 13'd0))
                             || ((rem100 == 13'd0) && (q_reg[1:0] == 2'd0));
                    qp_next   = (rem100 == 13'd0) ? q_reg - 6'd1 : q_reg;
                end
                gda_pkg::UOP_DN_MUL:
                begin
                    acc_next = mul365[20:0];
                end
                gda_pkg::UOP_DN_ADD:
                begin
                    acc_next = dn_sum;
                end
                gda_pkg::UOP_ADD_INIT:
                begin
                    d_next = 17'(da_reg) + 17'(add_reg);
                end
                gda_pkg::UOP_MONTH:
                begin
                    d_next = d_reg - 17'(mdays);
                    if (m_reg == 4'd12)
                    begin
                        m_next = 4'd1;
                        y_next = y_reg + 13'd1;
                    end
                    else
                    begin
                        m_next = m_reg + 4'd1;
                    end
                end
                gda_pkg::UOP_YEAR:
                begin
                    d_next = d_reg - 17'(year_len);
                    y_next = y_reg + 13'd1;
                end
                gda_pkg::UOP_OUT_DIFF, gda_pkg::UOP_OUT_SUM,
                gda_pkg::UOP_OUT_INV, gda_pkg::UOP_OUT_OVF:
                begin
                    if (out_hold)
                    begin
                        pc_next = pc_reg;
                    end
                    else
                    begin
                        busy_next      = 1'b0;
                        out_valid_next = 1'b1;
                        status_next    = gda_pkg::STATUS_OK;
                        diff_next      = '0;
                        rday_next      = '0;
                        rmon_next      = '0;
                        ryear_next     = '0;
                        case (uw.op)
                            gda_pkg::UOP_OUT_DIFF:
                            begin
                                diff_next = diff_val;
                            end
                            gda_pkg::UOP_OUT_SUM:
                            begin
                                rday_next  = d_reg[4:0];
                                rmon_next  = m_reg;
                                ryear_next = y_reg[11:0];
                            end
                            gda_pkg::UOP_OUT_OVF:
                            begin
                                status_next = gda_pkg::STATUS_YEAR_OVF;
                                rday_next   = 5'd31;
                                rmon_next   = 4'd12;
                                ryear_next  = LIM_OUT;
                            end
                            default:
                            begin
                                status_next = gda_pkg::STATUS_BAD_DATE;
                            end
                        endcase
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        da_reg     <= da_next;
        ma_reg     <= ma_next;
        ya_reg     <= ya_next;
        db_reg     <= db_next;
        mb_reg     <= mb_next;
        yb_reg     <= yb_next;
        add_reg    <= add_next;
        y_reg      <= y_next;
        m_reg      <= m_next;
        d_reg      <= d_next;
        q_reg      <= q_next;
        qp_reg     <= qp_next;
        leap_reg   <= leap_next;
        acc_reg    <= acc_next;
        na_reg     <= na_next;
        status_reg <= status_next;
        diff_reg   <= diff_next;
        rday_reg   <= rday_next;
        rmon_reg   <= rmon_next;
        ryear_reg  <= ryear_next;
    end

    // ports
    assign in_stall       = busy_reg;
    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign day_difference = $signed(diff_reg);
    assign result_day     = rday_reg;
    assign result_month   = rmon_reg;
    assign result_year    = ryear_reg;

endmodule

// ===== sv/gda_checker.sv =====
// port-level checks for the gregorian date arithmetic block, bound to the top level
`include "assert_macros.svh"

module gda_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic [1:0]         status,
    input logic signed [21:0] day_difference,
    input logic [4:0]         result_day,
    input logic [3:0]         result_month,
    input logic [11:0]        result_year
);

    // a stalled result keeps its status
    `GDA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status))

    // one item at a time: an accepted item closes the input
    `GDA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

    // a bad date gives all-zero result fields
    `GDA_ASSERT_NOW(a_bad_date_zero, out_valid && (status == gda_pkg::STATUS_BAD_DATE),
        (day_difference == 22'sd0) && (result_day == 5'd0) && (result_month == 4'd0)
        && (result_year == 12'd0))

    // year overflow saturates to the last day of the year
    `GDA_ASSERT_NOW(a_overflow_sat, out_valid && (status == gda_pkg::STATUS_YEAR_OVF),
        (result_day == 5'd31) && (result_month == 4'd12) && (day_difference == 22'sd0))

    // only one operation's fields carry a value
    `GDA_ASSERT_NOW(a_one_operation, out_valid,
        (day_difference == 22'sd0) || ((result_day == 5'd0) && (result_year == 12'd0)))

endmodule

bind gregorian_date_arithmetic gda_checker u_gda_checker (.*);
